/* rtl/ptts_pkg.sv */
// Package for the periodic task tick scheduler.
// Holds the request/result structs, the code constants, the controller
// state type and the command/status structs. It depends on nothing else.
package ptts_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int SLOT_W     = 4;
  localparam int TIME_W     = 32;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_START  = 2'd1;
  localparam logic [1:0] MODE_STOP   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] KIND_DUE     = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_ACK     = 2'd2;

  localparam logic [1:0] RS_STOPPED  = 2'd0;
  localparam logic [1:0] RS_RUNNING  = 2'd1;
  localparam logic [1:0] RS_STOPPING = 2'd2;

  localparam logic [TIME_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] period_ms;
    logic [TIME_W-1:0] delta_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] task_slot;
    logic [TIME_W-1:0] elapsed_ms;
    logic [TIME_W-1:0] next_wake_ms;
    logic              last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_UPD,
    ST_WB,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic take_cmd;   // apply a start or stop request and acknowledge it
    logic take_tick;  // capture delta, rewind the slot walk
    logic eval;
    logic upd;
    logic wb;
    logic next_idx;
    logic sum;
  } cmd_t;

  typedef struct packed {
    logic running;
    logic idx_last;
  } status_t;

endpackage

/* rtl/ptts_ctrl.sv */
// Controller of the periodic task tick scheduler: walks the slots on a tick.
// Depends on ptts_pkg; drives ptts_dp through cmd_t and reads status_t.
module ptts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ptts_pkg::req_t    request,
  input  ptts_pkg::status_t status,
  output ptts_pkg::cmd_t    cmd,
  output logic              busy
);
  import ptts_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (request.mode == MODE_START || request.mode == MODE_STOP) begin
            cmd.take_cmd = 1'b1;
          end else if (request.mode == MODE_TICK && request.delta_ms != '0) begin
            cmd.take_tick = 1'b1;
            state_next    = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (status.running) begin
          cmd.eval   = 1'b1;
          state_next = ST_UPD;
        end else if (status.idx_last) begin
          state_next = ST_SUM;
        end else begin
          cmd.next_idx = 1'b1;
        end
      end
      ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = ST_WB;
      end
      ST_WB: begin
        cmd.wb = 1'b1;
        if (status.idx_last) begin
          state_next = ST_SUM;
        end else begin
          cmd.next_idx = 1'b1;
          state_next   = ST_EVAL;
        end
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/ptts_dp.sv */
// Datapath of the periodic task tick scheduler: slot tables, the per-slot
// update arithmetic and the result register. Depends on ptts_pkg.
module ptts_dp (
  input  logic              clk,
  input  logic              rst,
  input  ptts_pkg::req_t    request,
  input  ptts_pkg::cmd_t    cmd,
  output ptts_pkg::status_t status,
  output ptts_pkg::rsp_t    result,
  output logic              strobe
);
  import ptts_pkg::*;

  logic [1:0]        run_state [TASK_SLOTS];
  logic [TIME_W-1:0] rem_tab   [TASK_SLOTS];
  logic [TIME_W-1:0] per_tab   [TASK_SLOTS];

  logic [IDX_W-1:0]  idx;
  logic [TIME_W-1:0] delta;
  logic [TIME_W-1:0] wake;
  logic              due;
  logic [TIME_W-1:0] diff;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] rem_r;
  logic [TIME_W-1:0] per_r;
  logic [TIME_W:0]   reload;

  logic              slot_ok;
  logic [IDX_W-1:0]  req_idx;
  logic [TIME_W:0]   diff_ext;
  logic [TIME_W:0]   sum_next;
  logic [TIME_W:0]   s_upd;
  logic [TIME_W:0]   e_upd;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W:0]   delta_ext;
  logic [TIME_W:0]   reload_next;
  logic [TIME_W+1:0] r_wb;
  logic [TIME_W-1:0] rem_new;

  assign slot_ok = (32'(request.slot) < TASK_SLOTS);
  assign req_idx = IDX_W'(request.slot);

  assign status.running  = (run_state[idx] == RS_RUNNING);
  assign status.idx_last = (idx == IDX_W'(TASK_SLOTS - 1));

  // Evaluate: the borrow of delta - remaining tells whether the slot is due.
  assign diff_ext = {1'b0, delta} - {1'b0, rem_tab[idx]};
  assign sum_next = {1'b0, rem_tab[idx]} + {1'b0, per_tab[idx]};

  // Elapsed is period + (delta - remaining) - 1, clamped to [1, all ones].
  assign delta_ext = {1'b0, delta};
  assign s_upd     = {1'b0, per_r} + {1'b0, diff};
  assign e_upd     = s_upd - 33'd1;
  always_comb begin
    priority if (s_upd <= 33'd1) begin
      elapsed = 32'd1;
    end else if (e_upd[TIME_W]) begin
      elapsed = ALL_ONES;
    end else begin
      elapsed = e_upd[TIME_W-1:0];
    end
  end

  // A late task is pushed to the next frame: at least delta + 1 before the
  // subtraction below.
  always_comb begin
    if (!due) begin
      reload_next = {1'b0, rem_r};
    end else if (sum <= delta_ext) begin
      reload_next = delta_ext + 33'd1;
    end else begin
      reload_next = sum;
    end
  end

  assign r_wb    = {1'b0, reload} - {2'b00, delta};
  assign rem_new = (r_wb[TIME_W+1:TIME_W] != 2'b00) ? ALL_ONES : r_wb[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        run_state[i] <= RS_STOPPED;
      end
    end else if (cmd.take_cmd && slot_ok) begin
      if (request.mode == MODE_START && run_state[req_idx] != RS_RUNNING) begin
        run_state[req_idx] <= RS_RUNNING;
      end else if (request.mode == MODE_STOP && run_state[req_idx] == RS_RUNNING) begin
        run_state[req_idx] <= RS_STOPPING;
      end
    end else if (cmd.sum) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        if (run_state[i] == RS_STOPPING) begin
          run_state[i] <= RS_STOPPED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_cmd && slot_ok && request.mode == MODE_START &&
        run_state[req_idx] != RS_RUNNING) begin
      per_tab[req_idx] <= request.period_ms;
      rem_tab[req_idx] <= request.period_ms;
    end else if (cmd.wb) begin
      rem_tab[idx] <= rem_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_tick) begin
      delta <= request.delta_ms;
      wake  <= ALL_ONES;
    end else if (cmd.wb && rem_new < wake) begin
      wake <= rem_new;
    end
    if (cmd.eval) begin
      due   <= !diff_ext[TIME_W];
      diff  <= diff_ext[TIME_W-1:0];
      sum   <= sum_next;
      rem_r <= rem_tab[idx];
      per_r <= per_tab[idx];
    end
    if (cmd.upd) begin
      reload <= reload_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.take_tick) begin
      idx <= '0;
    end else if (cmd.next_idx) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.take_cmd || (cmd.upd && due) || cmd.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_cmd) begin
      result <= '{kind: KIND_ACK, task_slot: '0, elapsed_ms: '0,
                  next_wake_ms: '0, last: 1'b1};
    end else if (cmd.upd) begin
      result <= '{kind: KIND_DUE, task_slot: SLOT_W'(idx), elapsed_ms: elapsed,
                  next_wake_ms: '0, last: 1'b0};
    end else if (cmd.sum) begin
      result <= '{kind: KIND_SUMMARY, task_slot: '0, elapsed_ms: '0,
                  next_wake_ms: wake, last: 1'b1};
    end
  end

endmodule

/* rtl/periodic_task_tick_scheduler_core.sv */
// Top level of the periodic task tick scheduler: controller plus datapath.
// Depends on ptts_pkg, ptts_ctrl and ptts_dp.
//
//   channel   ports                   handshake
//   request   start, busy, request    taken at an edge with start high, busy low
//   result    strobe, result          one cycle per result, no back-pressure
//
// A start or stop request is acknowledged in the cycle after it is taken and
// busy stays low. A tick walks the slots one at a time: a slot that is not
// running only passes the evaluate state, a running slot passes evaluate,
// update and write back, and the summary follows the last slot. A tick with
// zero delta or an unused mode is taken and gives nothing.
// Reset is synchronous; it stops all slots. The receiver cannot stall.
module periodic_task_tick_scheduler_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ptts_pkg::req_t request,
  output logic           strobe,
  output ptts_pkg::rsp_t result
);
  import ptts_pkg::*;

  cmd_t    cmd;
  status_t status;

  ptts_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  ptts_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .status  (status),
    .result  (result),
    .strobe  (strobe)
  );

  // A start or stop request is acknowledged in the very next cycle.
  a_ack_next: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.mode == MODE_START || request.mode == MODE_STOP))
    |=> (strobe && result.kind == KIND_ACK && result.last))
    else $error("start/stop request not acknowledged");

  // The summary closes the tick, so the block is free while it is shown.
  a_sum_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.kind == KIND_SUMMARY) |-> (!busy && result.last))
    else $error("summary shown while still busy");

  // Task-due results only appear inside a tick walk and never end it.
  a_due_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.kind == KIND_DUE) |-> (busy && !result.last))
    else $error("task-due result outside a tick walk");

  // A tick with zero delta causes no result.
  a_zero_tick: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.mode == MODE_TICK && request.delta_ms == '0)
    |=> !strobe)
    else $error("zero-delta tick produced a result");

endmodule
